@@ design/ssmks_pkg.sv @@
// Shared types and constants for the seven-segment display multiplexer with key scan.
// Holds the glyph table, slot and key-code enums and the interface structs.
// No dependencies.
package ssmks_pkg;

  localparam int unsigned CntW          = 12;
  localparam int unsigned MaxDigitSlots = 6;
  localparam int unsigned Glyphs        = 35;

  localparam logic [CntW-1:0] PressMinRst  = 12'd30;
  localparam logic [CntW-1:0] LongStartRst = 12'd2000;
  localparam logic [CntW-1:0] LongEndRst   = 12'd2500;
  localparam logic [CntW-1:0] CountCapRst  = 12'd3000;

  localparam logic [2:0] WrStatus0 = 3'd6;
  localparam logic [2:0] WrStatus1 = 3'd7;

  localparam logic [7:0] GLYPH_TAB [Glyphs] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90,
    8'h40, 8'h79, 8'h24, 8'h30, 8'h19, 8'h12, 8'h02, 8'h78, 8'h00, 8'h10,
    8'hc6, 8'h89, 8'h8c, 8'hdc, 8'he3, 8'h86, 8'haf, 8'hbf, 8'hff, 8'hc7,
    8'h88, 8'ha1, 8'h83, 8'he3, 8'ha3
  };

  typedef enum logic [1:0] {
    CFG_PRESS_MIN,
    CFG_LONG_START,
    CFG_LONG_END,
    CFG_COUNT_CAP
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_SHORT,
    KEY_LONG
  } key_code_e;

  typedef enum logic [3:0] {
    SLOT_D0,
    SLOT_D1,
    SLOT_D2,
    SLOT_D3,
    SLOT_D4,
    SLOT_D5,
    SLOT_S0,
    SLOT_S1,
    SLOT_BLANK
  } slot_e;

  typedef struct packed {
    logic [CntW-1:0] press_min;
    logic [CntW-1:0] long_start;
    logic [CntW-1:0] long_end;
    logic [CntW-1:0] count_cap;
  } key_cfg_t;

  typedef struct packed {
    logic      valid;
    logic [1:0] slot;
    key_code_e code;
    logic      reload;
  } key_res_t;

  typedef struct packed {
    logic [7:0] digit_select;
    logic [7:0] segment_out;
    logic       key_valid;
    logic [1:0] key_slot;
    logic [1:0] key_code;
    logic       timeout_reload;
  } result_t;

  // Active-high segment pattern of a glyph code; unknown codes give all segments off.
  function automatic logic [7:0] glyph_pattern(input logic [7:0] code);
    logic [7:0] pat;
    pat = 8'hff;
    if (code < 8'(Glyphs)) begin
      pat = GLYPH_TAB[code[5:0]];
    end
    return ~pat;
  endfunction

endpackage

@@ design/ssmks_key_scan.sv @@
// Press counters and press classification for the keys on the shared key line.
// Depends on ssmks_pkg for the configuration and result structs.
module ssmks_key_scan #(
  parameter int unsigned KEYS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                scan_i,
  input  logic [1:0]          key_i,
  input  logic                level_i,
  input  ssmks_pkg::key_cfg_t cfg_i,
  output ssmks_pkg::key_res_t res_o
);
  import ssmks_pkg::*;

  logic [CntW-1:0] cnt_q [KEYS];
  logic [CntW-1:0] cnt_sel;
  logic [CntW-1:0] cnt_d;
  logic            hit;
  logic            upd;
  key_code_e       code;
  logic            reload;

  always_comb begin
    cnt_sel = '0;
    hit     = 1'b0;
    for (int i = 0; i < KEYS; i++) begin
      if (key_i == 2'(i)) begin
        cnt_sel = cnt_q[i];
        hit     = 1'b1;
      end
    end
  end

  always_comb begin
    code   = KEY_NONE;
    reload = 1'b0;
    if (!level_i) begin
      cnt_d = (cnt_sel < cfg_i.count_cap) ? cnt_sel + 12'd1 : cnt_sel;
      reload = (cnt_d == cfg_i.press_min);
      if (cnt_d >= cfg_i.press_min && cnt_d >= cfg_i.long_start &&
          cnt_d < cfg_i.long_end) begin
        code = KEY_LONG;
      end
    end else begin
      cnt_d = '0;
      if (cnt_sel >= cfg_i.press_min && cnt_sel < cfg_i.long_start) begin
        code   = KEY_SHORT;
        reload = 1'b1;
      end
    end
  end

  assign upd = scan_i && hit;

  assign res_o.valid  = upd;
  assign res_o.slot   = upd ? key_i : 2'd0;
  assign res_o.code   = upd ? code : KEY_NONE;
  assign res_o.reload = upd && reload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEYS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < KEYS; i++) begin
        if (key_i == 2'(i)) begin
          cnt_q[i] <= cnt_d;
        end
      end
    end
  end

  property p_cap_held;
    @(posedge clk_i) disable iff (!rst_ni)
      upd && !level_i && cnt_sel >= cfg_i.count_cap |=> 1'b1 ##0 $past(cnt_d) == $past(cnt_sel);
  endproperty
  a_cap_held: assert property (p_cap_held) else $error("press counter moved past its cap");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && level_i |-> cnt_d == '0)
    else $error("release did not clear the press counter");

  a_long_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.code == KEY_LONG |-> res_o.valid && !level_i)
    else $error("long press reported without a held key");

endmodule

@@ design/seven_segment_mux_with_key_scan.sv @@
// Top level of the multiplexed seven-segment display driver with shared-line key scan.
// Depends on ssmks_pkg and instantiates ssmks_key_scan.
//
//  Channel   Direction  Transfer when                  Carries
//  s_axis    in         s_axis_tvalid & s_axis_tready  refresh tick or display store write
//  m_axis    out        m_axis_tvalid & m_axis_tready  select, segments, key report
//  cfg       in         cfg_valid_i & cfg_ready_o      threshold register write
//
// One transfer is taken per cycle while s_axis_tready is high; its result is registered.
// A two-entry output buffer (output register plus skid register) sets the accept condition:
// s_axis_tready is low only while the skid register is full.
// Writes and ticks of the blank slot produce no result.
// Reset clears the slot sequencer, press counters and display stores and loads the default
// thresholds.
module seven_segment_mux_with_key_scan #(
  parameter int unsigned DIGITS = 6,
  parameter int unsigned KEYS   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] write_index, [10:3] write_value, [11] key_level, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] digit_select, [15:8] segment_out, [17:16] key_slot, [19:18] key_code,
  // [20] timeout_reload, [23:21] zero
  output logic [23:0] m_axis_tdata,
  // [0] key_valid
  output logic        m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import ssmks_pkg::*;

  localparam int unsigned DigitSlots = (DIGITS < MaxDigitSlots) ? DIGITS : MaxDigitSlots;

  key_cfg_t   cfg_q;
  slot_e      slot_q, slot_d;
  logic       dwell_q, dwell_d;
  logic [7:0] digit_q [DigitSlots];
  logic [7:0] status0_q, status1_q;

  result_t    out_q, out_d, skid_q, skid_d, res;
  logic       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic       in_acc, tick, wr, gen, out_take;
  logic [2:0] wr_idx;
  logic [7:0] wr_val;
  logic       key_level;

  logic       res_vld, scan;
  logic [1:0] scan_key;
  logic [7:0] dig_seg;
  logic [7:0] seg;
  key_res_t   key_res;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign tick          = in_acc && !s_axis_tuser;
  assign wr            = in_acc && s_axis_tuser;
  assign wr_idx        = s_axis_tdata[2:0];
  assign wr_val        = s_axis_tdata[10:3];
  assign key_level     = s_axis_tdata[11];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_min  <= PressMinRst;
      cfg_q.long_start <= LongStartRst;
      cfg_q.long_end   <= LongEndRst;
      cfg_q.count_cap  <= CountCapRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PRESS_MIN:  cfg_q.press_min  <= cfg_data_i;
        CFG_LONG_START: cfg_q.long_start <= cfg_data_i;
        CFG_LONG_END:   cfg_q.long_end   <= cfg_data_i;
        CFG_COUNT_CAP:  cfg_q.count_cap  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DigitSlots; i++) begin
        digit_q[i] <= '0;
      end
      status0_q <= '0;
      status1_q <= '0;
    end else if (wr) begin
      for (int i = 0; i < DigitSlots; i++) begin
        if (wr_idx == 3'(i)) begin
          digit_q[i] <= wr_val;
        end
      end
      if (wr_idx == WrStatus0) begin
        status0_q <= wr_val;
      end
      if (wr_idx == WrStatus1) begin
        status1_q <= wr_val;
      end
    end
  end

  always_comb begin
    slot_d  = slot_q;
    dwell_d = dwell_q;
    if (tick) begin
      unique case (slot_q)
        SLOT_D0, SLOT_D1, SLOT_D2, SLOT_S0, SLOT_S1: begin
          slot_d = slot_e'(4'(slot_q) + 4'd1);
        end
        SLOT_D3, SLOT_D4, SLOT_D5: begin
          if (dwell_q) begin
            dwell_d = 1'b0;
            slot_d  = slot_e'(4'(slot_q) + 4'd1);
          end else begin
            dwell_d = 1'b1;
          end
        end
        default: begin
          slot_d  = SLOT_D0;
          dwell_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SLOT_D0;
      dwell_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      dwell_q <= dwell_d;
    end
  end

  always_comb begin
    dig_seg = 8'h00;
    for (int i = 0; i < DigitSlots; i++) begin
      if (4'(slot_q) == 4'(i)) begin
        dig_seg = glyph_pattern(digit_q[i]);
      end
    end
  end

  always_comb begin
    res_vld  = 1'b1;
    scan     = 1'b0;
    scan_key = 2'd0;
    seg      = dig_seg;
    unique case (slot_q)
      SLOT_D0: begin
        scan     = 1'b1;
        scan_key = 2'd0;
      end
      SLOT_D2: begin
        scan     = 1'b1;
        scan_key = 2'd1;
      end
      SLOT_D4: begin
        scan     = 1'b1;
        scan_key = 2'd2;
      end
      SLOT_S0: begin
        scan     = 1'b1;
        scan_key = 2'd3;
        seg      = status0_q;
      end
      SLOT_S1: begin
        seg = status1_q;
      end
      SLOT_D1, SLOT_D3, SLOT_D5: ;
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  ssmks_key_scan #(
    .KEYS (KEYS)
  ) u_key_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (tick && scan),
    .key_i   (scan_key),
    .level_i (key_level),
    .cfg_i   (cfg_q),
    .res_o   (key_res)
  );

  always_comb begin
    res.digit_select   = ~(8'd1 << slot_q[2:0]);
    res.segment_out    = seg;
    res.key_valid      = key_res.valid;
    res.key_slot       = key_res.slot;
    res.key_code       = key_res.code;
    res.timeout_reload = key_res.reload;
  end

  assign gen      = tick && res_vld;
  assign out_take = out_valid_q && m_axis_tready;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q && out_take) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end
    if (gen) begin
      if (!out_valid_q || out_take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.key_valid;
  assign m_axis_tdata  = {3'b000, out_q.timeout_reload, out_q.key_code, out_q.key_slot,
                          out_q.segment_out, out_q.digit_select};

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register is empty");

  a_dwell_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dwell_q |-> (slot_q == SLOT_D3 || slot_q == SLOT_D4 || slot_q == SLOT_D5))
    else $error("dwell flag set outside a dwelling slot");

  a_write_holds_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> $stable(slot_q) && $stable(dwell_q))
    else $error("display write moved the slot sequencer");

  a_key_in_scan_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[7:0] == 8'hfe || m_axis_tdata[7:0] == 8'hfb ||
       m_axis_tdata[7:0] == 8'hef || m_axis_tdata[7:0] == 8'hbf))
    else $error("key report in a slot without a key scan");

endmodule
